>>> hw/rtl/stat_pkg.sv
// shared types and constants for the section table address translator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package stat_pkg;
  localparam int MaxSections = 96;
  localparam int IdxW = 7;
  localparam int AddrW = 4;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_FIND = 2'd1,
    REQ_OFF2RVA = 2'd2,
    REQ_RVA2OFF = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_NOMATCH = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_RAW_OUTSIDE = 3'd3,
    ST_RAW_HEADERS = 3'd4,
    ST_MAPPED_4G = 3'd5,
    ST_RAW_OVERLAP = 3'd6,
    ST_MAPPED_OVERLAP = 3'd7
  } status_t;

  localparam logic [3:0] REG_COUNT = 4'h0;
  localparam logic [3:0] REG_IMAGE = 4'h4;
  localparam logic [3:0] REG_HEADERS = 4'h8;
endpackage
`default_nettype wire

>>> hw/rtl/section_table_address_translator_unit.sv
// section table address translator, top level
// depends on stat_pkg
//
// usage: start with busy low accepts one transaction from the in_ ports.
// the block then scans the section table with one shared compare unit,
// a registered table read, then a compare, for each entry; busy stays
// high for the whole transaction.
// the scan compares up to index entries for a load, stopping at the first
// overlap, entries up to the first match for a query, and none when a
// check fails before the scan; the next transaction can be accepted at
// the edge that ends the result cycle.
// the result appears for one cycle with out_valid; the receiver cannot
// stall it.
// reset (rst_n low, synchronous) returns to idle and sets section_count
// to 1, image_size and headers_end to 0; table contents are undefined
// until loaded and need no clearing pass.
// configuration goes through the apb port at byte addresses 0, 4 and 8;
// the user must write it only while idle, the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module section_table_address_translator_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic [1:0] in_req_type,
  input  wire logic [6:0] in_section_index,
  input  wire logic [31:0] in_virtual_size,
  input  wire logic [31:0] in_virtual_address,
  input  wire logic [31:0] in_raw_size,
  input  wire logic [31:0] in_raw_pointer,
  input  wire logic in_section_executable,
  input  wire logic [31:0] in_file_offset,
  input  wire logic [31:0] in_rva_in,
  input  wire logic [31:0] in_access_length,
  input  wire logic in_executable_only,
  output logic out_valid,
  output logic [2:0] out_status,
  output logic [6:0] out_found_index,
  output logic [31:0] out_address_out,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [stat_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import stat_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_READ, S_EVAL, S_DONE} state_t;

  state_t state_r;
  logic [6:0] cnt_r;
  logic [31:0] img_r, hdr_r;
  logic [6:0] n_eff;
  assign n_eff = (cnt_r > 7'(MaxSections)) ? 7'(MaxSections) : cnt_r;

  logic [63:0] raw_mem [MaxSections];
  logic [63:0] map_mem [MaxSections];
  logic exe_mem [MaxSections];
  logic [63:0] raw_rd_r, map_rd_r;
  logic exe_rd_r;

  req_t req_r;
  logic [6:0] idx_r, ptr_r;
  logic [31:0] va_r, rsz_r, rptr_r, mlen_r, off_r, rva_r, len_r;
  logic xo_r;
  logic [2:0] st_r;
  logic [6:0] fidx_r;
  logic [31:0] addr_r;
  logic valid_r;
  logic wr_en;
  logic [31:0] mlen_in;
  assign mlen_in = (in_virtual_size != 32'd0) ? in_virtual_size : in_raw_size;
  assign wr_en = start && !busy && (in_req_type == REQ_LOAD) && (in_section_index < n_eff);

  assign pready = 1'b1;
  assign busy = (state_r != S_IDLE);
  assign out_valid = valid_r;
  assign out_status = st_r;
  assign out_found_index = fidx_r;
  assign out_address_out = addr_r;

  always_comb begin
    unique case (paddr)
      REG_COUNT: prdata = {25'd0, cnt_r};
      REG_IMAGE: prdata = img_r;
      REG_HEADERS: prdata = hdr_r;
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      raw_mem[in_section_index] <= {in_raw_size, in_raw_pointer};
      map_mem[in_section_index] <= {mlen_in, in_virtual_address};
      exe_mem[in_section_index] <= in_section_executable;
    end
    raw_rd_r <= raw_mem[ptr_r];
    map_rd_r <= map_mem[ptr_r];
    exe_rd_r <= exe_mem[ptr_r];
  end

  // entry compare unit
  logic [32:0] os, osz, ova, olen, orend, omend, rend, mend, rel, q_off, q_len;
  logic hit_raw_ov, hit_map_ov, find_ok, r2o_ok;
  logic [32:0] rs_rel;
  always_comb begin
    os = {1'b0, raw_rd_r[31:0]};
    osz = {1'b0, raw_rd_r[63:32]};
    ova = {1'b0, map_rd_r[31:0]};
    olen = {1'b0, map_rd_r[63:32]};
    orend = os + osz;
    omend = ova + olen;
    rend = {1'b0, rptr_r} + {1'b0, rsz_r};
    mend = {1'b0, va_r} + {1'b0, mlen_r};
    q_off = {1'b0, off_r};
    q_len = {1'b0, len_r};
    hit_raw_ov = (rsz_r != 0) && (osz != 0) && ({1'b0, rptr_r} < orend) && (os < rend);
    hit_map_ov = (mlen_r != 0) && (olen != 0) && ({1'b0, va_r} < omend) && (ova < mend);
    find_ok = !(xo_r && (req_r == REQ_FIND) && !exe_rd_r) && (osz != 0) && (q_off >= os)
              && (q_off <= orend) && (q_len <= orend - q_off)
              && ((q_off - os) + q_len <= olen);
    rel = {1'b0, rva_r} - ova;
    rs_rel = os + rel;
    r2o_ok = (osz != 0) && ({1'b0, rva_r} >= ova) && (rel <= olen) && (q_len <= olen - rel)
             && (rel <= osz) && (q_len <= osz - rel) && (rs_rel <= {1'b0, img_r})
             && (q_len <= {1'b0, img_r} - rs_rel);
  end

  logic [32:0] v_o2r;
  assign v_o2r = ova + (q_off - os);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      cnt_r <= 7'd1;
      img_r <= 32'd0;
      hdr_r <= 32'd0;
    end else begin
      valid_r <= 1'b0;
      if (psel && penable && pwrite) begin
        unique case (paddr)
          REG_COUNT: cnt_r <= pwdata[6:0];
          REG_IMAGE: img_r <= pwdata;
          REG_HEADERS: hdr_r <= pwdata;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r <= req_t'(in_req_type);
            idx_r <= in_section_index;
            va_r <= in_virtual_address;
            rsz_r <= in_raw_size;
            rptr_r <= in_raw_pointer;
            mlen_r <= mlen_in;
            off_r <= in_file_offset;
            rva_r <= in_rva_in;
            len_r <= in_access_length;
            xo_r <= in_executable_only;
            ptr_r <= 7'd0;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          st_r <= ST_OK;
          fidx_r <= 7'd0;
          addr_r <= 32'd0;
          state_r <= S_READ;
          if (req_r == REQ_LOAD) begin
            fidx_r <= idx_r;
            priority if (idx_r >= n_eff) begin
              st_r <= ST_BAD_INDEX; fidx_r <= 7'd0; state_r <= S_DONE;
            end else if (rptr_r > img_r || rsz_r > img_r - rptr_r) begin
              st_r <= ST_RAW_OUTSIDE; fidx_r <= 7'd0; state_r <= S_DONE;
            end else if (rsz_r != 0 && rptr_r < hdr_r) begin
              st_r <= ST_RAW_HEADERS; fidx_r <= 7'd0; state_r <= S_DONE;
            end else if (mend > 33'h1_0000_0000) begin
              st_r <= ST_MAPPED_4G; fidx_r <= 7'd0; state_r <= S_DONE;
            end else if (idx_r == 7'd0) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_READ;
            end
          end else begin
            st_r <= ST_NOMATCH;
            if (len_r == 0 || (req_r != REQ_RVA2OFF
                && (off_r > img_r || len_r > img_r - off_r)) || n_eff == 7'd0)
              state_r <= S_DONE;
          end
        end
        S_READ: state_r <= S_EVAL;
        S_EVAL: begin
          state_r <= S_READ;
          if (req_r == REQ_LOAD) begin
            priority if (hit_raw_ov) begin
              st_r <= ST_RAW_OVERLAP; fidx_r <= 7'd0; state_r <= S_DONE;
            end else if (hit_map_ov) begin
              st_r <= ST_MAPPED_OVERLAP; fidx_r <= 7'd0; state_r <= S_DONE;
            end else if (ptr_r + 7'd1 >= idx_r) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_READ;
            end
          end else begin
            priority if (req_r == REQ_RVA2OFF ? r2o_ok : find_ok) begin
              state_r <= S_DONE;
              if (req_r == REQ_FIND) begin
                st_r <= ST_OK; fidx_r <= ptr_r;
              end else if (req_r == REQ_OFF2RVA) begin
                if (!v_o2r[32]) begin
                  st_r <= ST_OK; fidx_r <= ptr_r; addr_r <= v_o2r[31:0];
                end
              end else begin
                st_r <= ST_OK; fidx_r <= ptr_r; addr_r <= rs_rel[31:0];
              end
            end else if (ptr_r + 7'd1 >= n_eff) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_READ;
            end
          end
          ptr_r <= ptr_r + 7'd1;
        end
        S_DONE: begin
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> tb/section_table_address_translator_unit_test.sv
// self-checking testbench for section_table_address_translator_unit
// drives loads and queries, predicts every result and checks it; depends on stat_pkg
`timescale 1ns / 1ps
module section_table_address_translator_unit_test;
  import stat_pkg::*;

  typedef struct packed {
    req_t req;
    logic [6:0] sidx;
    logic [31:0] vsize, vaddr, rsize, rptr;
    logic sexec;
    logic [31:0] foff, rva, alen;
    logic exec_only;
  } xact_t;

  typedef struct packed {
    status_t status;
    logic [6:0] idx;
    logic [31:0] addr;
  } result_t;

  logic clk = 0, rst_n = 0, start = 0;
  logic busy, out_valid, pready;
  logic [2:0] out_status;
  logic [6:0] out_found_index;
  logic [31:0] out_address_out, prdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  xact_t cur = '0;

  section_table_address_translator_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(cur.req), .in_section_index(cur.sidx), .in_virtual_size(cur.vsize),
    .in_virtual_address(cur.vaddr), .in_raw_size(cur.rsize), .in_raw_pointer(cur.rptr),
    .in_section_executable(cur.sexec), .in_file_offset(cur.foff), .in_rva_in(cur.rva),
    .in_access_length(cur.alen), .in_executable_only(cur.exec_only),
    .out_valid(out_valid), .out_status(out_status), .out_found_index(out_found_index),
    .out_address_out(out_address_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial forever #5 clk = ~clk;

  xact_t pending_reqs[$];
  result_t expected_results[$];
  int errors = 0, accepted = 0, checked = 0, gap = 0, phases = 0;
  bit took = 0, no_idle = 0;

  // table and register copy for prediction
  logic [31:0] t_rs[MaxSections], t_rz[MaxSections], t_va[MaxSections], t_ml[MaxSections];
  bit t_ex[MaxSections];
  logic [6:0] m_count = 7'd1;
  logic [31:0] m_img = '0, m_hdr = '0;

  // stimulus-side view of what was loaded
  logic [31:0] g_rs[MaxSections], g_rz[MaxSections], g_va[MaxSections], g_ml[MaxSections];
  logic [31:0] rcur, vcur;

  function automatic int active_sections();
    return (m_count > MaxSections) ? MaxSections : int'(m_count);
  endfunction

  function automatic bit in_image(logic [63:0] off, logic [63:0] len);
    return off <= {32'd0, m_img} && len <= {32'd0, m_img} - off;
  endfunction

  function automatic int find_section(logic [63:0] off, logic [63:0] len, bit xo);
    logic [63:0] rs, rz, re;
    if (len == 0 || !in_image(off, len)) return -1;
    for (int i = 0; i < active_sections(); i++) begin
      rs = t_rs[i];
      rz = t_rz[i];
      re = rs + rz;
      if (xo && !t_ex[i]) continue;
      if (rz == 0 || off < rs || off > re || len > re - off) continue;
      if ((off - rs) + len > {32'd0, t_ml[i]}) continue;
      return i;
    end
    return -1;
  endfunction

  function automatic result_t predict_translation(xact_t it);
    result_t r;
    logic [63:0] mlen, rend, mend, v, rel, rz, ml;
    int hit;
    r = '{status: ST_NOMATCH, idx: 7'd0, addr: 32'd0};
    case (it.req)
      REQ_LOAD: begin
        if (int'(it.sidx) >= active_sections()) begin
          r.status = ST_BAD_INDEX;
          return r;
        end
        mlen = (it.vsize != 0) ? it.vsize : it.rsize;
        rend = 64'(it.rptr) + it.rsize;
        mend = 64'(it.vaddr) + mlen;
        t_rs[it.sidx] = it.rptr;
        t_rz[it.sidx] = it.rsize;
        t_va[it.sidx] = it.vaddr;
        t_ml[it.sidx] = mlen[31:0];
        t_ex[it.sidx] = it.sexec;
        r.status = ST_OK;
        if (!in_image(it.rptr, it.rsize)) r.status = ST_RAW_OUTSIDE;
        else if (it.rsize != 0 && it.rptr < m_hdr) r.status = ST_RAW_HEADERS;
        else if (mend > 64'h1_0000_0000) r.status = ST_MAPPED_4G;
        else begin
          for (int p = 0; p < int'(it.sidx) && r.status == ST_OK; p++) begin
            if (it.rsize != 0 && t_rz[p] != 0 && 64'(it.rptr) < 64'(t_rs[p]) + t_rz[p]
                && 64'(t_rs[p]) < rend)
              r.status = ST_RAW_OVERLAP;
            else if (mlen != 0 && t_ml[p] != 0 && 64'(it.vaddr) < 64'(t_va[p]) + t_ml[p]
                     && 64'(t_va[p]) < mend)
              r.status = ST_MAPPED_OVERLAP;
          end
        end
        if (r.status == ST_OK) r.idx = it.sidx;
      end
      REQ_FIND: begin
        hit = find_section(it.foff, it.alen, it.exec_only);
        if (hit >= 0) begin
          r.status = ST_OK;
          r.idx = hit[6:0];
        end
      end
      REQ_OFF2RVA: begin
        hit = find_section(it.foff, it.alen, 1'b0);
        if (hit >= 0) begin
          v = 64'(t_va[hit]) + (64'(it.foff) - t_rs[hit]);
          if (v <= 64'hFFFF_FFFF) begin
            r.status = ST_OK;
            r.idx = hit[6:0];
            r.addr = v[31:0];
          end
        end
      end
      default: begin
        if (it.alen != 0) begin
          for (int i = 0; i < active_sections(); i++) begin
            rz = t_rz[i];
            ml = t_ml[i];
            if (rz == 0 || it.rva < t_va[i]) continue;
            rel = 64'(it.rva) - t_va[i];
            if (rel > ml || it.alen > ml - rel || rel > rz || it.alen > rz - rel) continue;
            if (!in_image(64'(t_rs[i]) + rel, it.alen)) continue;
            r.status = ST_OK;
            r.idx = i[6:0];
            r.addr = t_rs[i] + rel[31:0];
            break;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic xact_t noise_item();
    xact_t it;
    it = xact_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom});
    it.sidx = 7'($urandom_range(0, MaxSections - 1));
    return it;
  endfunction

  // kind: 0 good, 1 outside image, 2 in headers, 3 past 4 GiB, 4 raw overlap,
  // 5 mapped overlap, 6 noise, 7 empty raw
  function automatic xact_t make_load(int idx, int kind);
    xact_t it;
    int p;
    it = noise_item();
    it.req = REQ_LOAD;
    it.sidx = idx[6:0];
    it.rsize = $urandom_range(1, 32'h3000);
    it.vsize = ($urandom_range(0, 2) == 0) ? 32'd0 : it.rsize + $urandom_range(0, 32'h800);
    it.rptr = rcur;
    it.vaddr = vcur;
    p = (idx > 0) ? $urandom_range(0, idx - 1) : 0;
    case (kind)
      1: it.rptr = m_img - it.rsize + $urandom_range(1, 32'h100);
      2: it.rptr = (m_hdr > 0) ? m_hdr - 1 : 32'd0;
      3: it.vaddr = 32'hFFFF_F000 + $urandom_range(0, 32'hFFF);
      4: if (idx > 0) it.rptr = g_rs[p];
      5: if (idx > 0) it.vaddr = g_va[p];
      6: ;
      7: it.rsize = 32'd0;
      default: ;
    endcase
    if (kind == 0 || kind == 7) begin
      rcur = rcur + it.rsize + $urandom_range(0, 32'h200);
      vcur = vcur + ((it.vsize != 0) ? it.vsize : it.rsize) + $urandom_range(0, 32'h1000);
    end
    g_rs[idx] = it.rptr;
    g_rz[idx] = it.rsize;
    g_va[idx] = it.vaddr;
    g_ml[idx] = (it.vsize != 0) ? it.vsize : it.rsize;
    return it;
  endfunction

  function automatic xact_t make_query(int n);
    xact_t it;
    int k;
    logic [31:0] rel, room;
    it = noise_item();
    it.req = req_t'($urandom_range(1, 3));
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 0) it.alen = 32'd0;
      return it;
    end
    k = $urandom_range(0, n - 1);
    rel = (g_rz[k] == 0) ? 32'd0 : $urandom_range(0, g_rz[k] - 1);
    room = g_rz[k] - rel;
    it.alen = (room == 0 || $urandom_range(0, 5) == 0) ? $urandom_range(0, 32'h4000)
                                                      : $urandom_range(1, room);
    it.foff = g_rs[k] + rel;
    it.rva = g_va[k] + rel;
    return it;
  endfunction

  task automatic cfg_write(logic [AddrW-1:0] a, logic [31:0] d);
    @(negedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= a;
    pwdata <= d;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (a)
      REG_COUNT: m_count = d[6:0];
      REG_IMAGE: m_img = d;
      default: m_hdr = d;
    endcase
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_results.size() != 0 || start || busy)
      @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  task automatic setup_phase(int n, logic [31:0] img, logic [31:0] hdr);
    drain();
    cfg_write(REG_COUNT, n);
    cfg_write(REG_IMAGE, img);
    cfg_write(REG_HEADERS, hdr);
    rcur = hdr + $urandom_range(0, 32'h100);
    vcur = $urandom_range(0, 32'h2000);
    phases++;
  endtask

  task automatic random_phase(int n, logic [31:0] img, logic [31:0] hdr, int queries);
    int kind;
    setup_phase(n, img, hdr);
    for (int i = 0; i < n; i++) begin
      kind = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
      pending_reqs.push_back(make_load(i, kind));
    end
    for (int q = 0; q < queries; q++) begin
      case ($urandom_range(0, 9))
        0: pending_reqs.push_back(make_load($urandom_range(0, n - 1), $urandom_range(0, 7)));
        1: pending_reqs.push_back(make_load($urandom_range(n, MaxSections - 1) % MaxSections,
                                            6));
        default: pending_reqs.push_back(make_query(n));
      endcase
    end
  endtask

  // driver
  always @(negedge clk) begin
    xact_t it;
    if (rst_n && !(start && !took)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 0;
      end else if (pending_reqs.size() != 0) begin
        if (!no_idle && $urandom_range(0, 4) == 0) begin
          gap <= $urandom_range(0, 4);
          start <= 0;
        end else begin
          it = pending_reqs.pop_front();
          cur <= it;
          start <= 1;
        end
      end else begin
        start <= 0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    result_t e;
    took <= rst_n && start && !busy;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d idx=%0d addr=%h", $time, out_status,
                 out_found_index, out_address_out);
        errors++;
      end else begin
        e = expected_results.pop_front();
        checked++;
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          errors++;
        end
        if (out_found_index !== e.idx) begin
          $display("%0t: found_index expected %0d actual %0d", $time, e.idx, out_found_index);
          errors++;
        end
        if (out_address_out !== e.addr) begin
          $display("%0t: address_out expected %h actual %h", $time, e.addr, out_address_out);
          errors++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      expected_results.push_back(predict_translation(cur));
      accepted++;
    end
  end

  initial begin
    #20_000_000;
    $display("section_table_address_translator_unit regression: fail");
    $finish;
  end

  initial begin
    xact_t it;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: every load outcome, bad indexes, each query type
    setup_phase(8, 32'h0001_0000, 32'h400);
    pending_reqs.push_back(make_load(0, 0));
    pending_reqs.push_back(make_load(1, 7));
    pending_reqs.push_back(make_load(2, 1));
    pending_reqs.push_back(make_load(3, 2));
    pending_reqs.push_back(make_load(4, 3));
    pending_reqs.push_back(make_load(5, 4));
    pending_reqs.push_back(make_load(6, 5));
    pending_reqs.push_back(make_load(7, 0));
    pending_reqs.push_back(make_load(8, 0));
    pending_reqs.push_back(make_load(95, 0));
    for (int t = 1; t < 4; t++) begin
      it = make_query(1);
      it.req = req_t'(t);
      it.alen = 32'd1;
      pending_reqs.push_back(it);
      it.alen = 32'd0;
      pending_reqs.push_back(it);
    end
    it = make_query(8);
    it.req = REQ_FIND;
    it.exec_only = 1;
    pending_reqs.push_back(it);
    it.foff = 32'hFFFF_FFFF;
    it.alen = 32'hFFFF_FFFF;
    pending_reqs.push_back(it);

    random_phase(1, 32'd0, 32'd0, 20);
    random_phase(96, 32'hFFFF_FFFF, 32'd0, 60);
    random_phase(5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20);
    random_phase(1, 32'hFFFF_FFFF, 32'h200, 30);
    while (accepted + pending_reqs.size() < 700)
      random_phase($urandom_range(1, 24), $urandom_range(32'h8000, 32'h40_0000),
                   $urandom_range(0, 32'h1000), $urandom_range(20, 60));
    drain();
    no_idle = 1;
    random_phase(16, 32'h0010_0000, 32'h400, 80);
    drain();

    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      errors++;
    end
    $display("covered %0d transactions over %0d register settings, %0d results checked",
             accepted, phases, checked);
    if (errors == 0)
      $display("section_table_address_translator_unit regression: pass");
    else
      $display("section_table_address_translator_unit regression: fail");
    $finish;
  end
endmodule

>>> files.f
hw/rtl/stat_pkg.sv
hw/rtl/section_table_address_translator_unit.sv
tb/section_table_address_translator_unit_test.sv
